>>> rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Types and constants shared by the fixed block pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

	localparam int DEF_MAX_BLOCKS = 1024;

	localparam int BLK_IDX_W   = 10;
	localparam int BLK_OFF_W   = 22;
	localparam int STATUS_W    = 2;
	localparam int FCNT_W      = 11;
	localparam int BB_W        = 13;
	localparam int INIT_W      = 11;
	localparam int ALIGNED_W   = 14;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BYTES = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INIT_FREE   = 1'd1;

	localparam logic [BB_W-1:0]   BLOCK_BYTES_RST = 13'd64;
	localparam logic [INIT_W-1:0] INIT_FREE_RST   = 11'd0;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

	typedef struct packed {
		logic                 mode;
		logic [BLK_IDX_W-1:0] free_block;
	} req_t;

	typedef struct packed {
		logic [BLK_IDX_W-1:0] block_index;
		logic [BLK_OFF_W-1:0] block_offset;
		logic [STATUS_W-1:0]  status;
		logic [FCNT_W-1:0]    free_count;
	} rsp_t;

endpackage

`default_nettype wire

>>> rtl/fixed_block_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// Fixed-size block pool: hands out block indices and byte offsets, takes
// freed indices back through a ring memory.
// ----------------------------------------------------------------------------
// One request (allocate or free) is taken per clock while the result side is
// not stalled; each result passes through the stage-1 register, which holds
// the registered read of the freed index ring, and then the output register,
// which takes the offset multiply. Pre-filled blocks go out first, then freed
// blocks in free order, then never-used indices. Writing init_free_count
// restarts the pool. The ring memory holds MAX_BLOCKS entries and needs no
// clearing pass: only entries written by a free are read.
`default_nettype none

module fixed_block_pool_allocator_top
	import fbpa_pkg::*;
#(
	parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	output logic                        req_stall,
	input  wire req_t                   req,
	output logic                        rsp_valid,
	input  wire logic                   rsp_stall,
	output rsp_t                        rsp,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int PTR_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int TOT_W = CNT_W + 1;
	localparam int IDX_W = (PTR_W > BLK_IDX_W) ? PTR_W : BLK_IDX_W;
	localparam int CMP_W = (CNT_W > INIT_W) ? CNT_W : INIT_W;
	localparam int PRD_W = IDX_W + ALIGNED_W;

	localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_BLOCKS);
	localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_BLOCKS);
	localparam logic [TOT_W-1:0] MAX_TOT  = TOT_W'(MAX_BLOCKS);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(MAX_BLOCKS - 1);

	// configuration
	logic [BB_W-1:0]   block_bytes_q;
	logic [INIT_W-1:0] init_free_q;

	// pool state
	logic [CNT_W-1:0] prefill_q;
	logic [CNT_W-1:0] bump_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] ring_cnt_q;

	logic [BLK_IDX_W-1:0] ring_mem [MAX_BLOCKS];

	// stage 1
	logic                 valid_s1;
	logic                 from_ring_s1;
	logic [PTR_W-1:0]     idx_s1;
	logic [STATUS_W-1:0]  status_s1;
	logic [FCNT_W-1:0]    fcnt_s1;
	logic [BLK_IDX_W-1:0] rd_s1;

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic [CNT_W-1:0]     eff_init;
	logic [CNT_W-1:0]     cfg_eff;
	logic [TOT_W-1:0]     total_now;
	logic [TOT_W-1:0]     total_next;
	logic                 accept;
	logic                 adv;
	logic                 take_prefill;
	logic                 take_ring;
	logic                 take_bump;
	logic                 free_ok;
	logic [STATUS_W-1:0]  status_d;
	logic [PTR_W-1:0]     idx_d;
	logic [ALIGNED_W-1:0] aligned_sum;
	logic [ALIGNED_W-1:0] aligned;
	logic [IDX_W-1:0]     idx_sel;
	logic [PRD_W-1:0]     product;

	assign eff_init = (CMP_W'(init_free_q) > MAX_CMP) ? MAX_CNT : CNT_W'(init_free_q);
	assign cfg_eff  = (CMP_W'(cfg_data[INIT_W-1:0]) > MAX_CMP) ?
		MAX_CNT : CNT_W'(cfg_data[INIT_W-1:0]);

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !adv;
	assign accept    = req_valid && !req_stall;

	assign total_now = TOT_W'(eff_init) - TOT_W'(prefill_q) + TOT_W'(ring_cnt_q);

	always_comb begin
		take_prefill = 1'b0;
		take_ring    = 1'b0;
		take_bump    = 1'b0;
		free_ok      = 1'b0;
		status_d     = ST_OK;
		idx_d        = '0;
		total_next   = total_now;
		if (req.mode == MODE_ALLOC) begin
			priority if (prefill_q < eff_init) begin
				take_prefill = 1'b1;
				idx_d        = PTR_W'(prefill_q);
				total_next   = total_now - 1'b1;
			end else if (ring_cnt_q != '0) begin
				take_ring  = 1'b1;
				total_next = total_now - 1'b1;
			end else if (bump_q < MAX_CNT) begin
				take_bump = 1'b1;
				idx_d     = PTR_W'(bump_q);
			end else begin
				status_d = ST_EXHAUSTED;
			end
		end else begin
			if (total_now >= MAX_TOT) begin
				status_d = ST_OVERFLOW;
			end else begin
				free_ok    = 1'b1;
				total_next = total_now + 1'b1;
			end
		end
	end

	// configuration registers and pool counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= BLOCK_BYTES_RST;
			init_free_q   <= INIT_FREE_RST;
			prefill_q     <= '0;
			bump_q        <= CNT_W'(INIT_FREE_RST);
			head_q        <= '0;
			tail_q        <= '0;
			ring_cnt_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLOCK_BYTES: begin
					block_bytes_q <= cfg_data;
				end
				REG_INIT_FREE: begin
					init_free_q <= cfg_data[INIT_W-1:0];
					prefill_q   <= '0;
					bump_q      <= cfg_eff;
					head_q      <= '0;
					tail_q      <= '0;
					ring_cnt_q  <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (take_prefill) begin
				prefill_q <= prefill_q + 1'b1;
			end
			if (take_bump) begin
				bump_q <= bump_q + 1'b1;
			end
			if (take_ring) begin
				head_q     <= (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
				ring_cnt_q <= ring_cnt_q - 1'b1;
			end
			if (free_ok) begin
				tail_q     <= (tail_q == LAST_PTR) ? '0 : tail_q + 1'b1;
				ring_cnt_q <= ring_cnt_q + 1'b1;
			end
		end
	end

	// freed index ring; the head is read in the transfer cycle
	always_ff @(posedge clk) begin
		if (accept && free_ok) begin
			ring_mem[tail_q] <= req.free_block;
		end
		if (accept && take_ring) begin
			rd_s1 <= ring_mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			from_ring_s1 <= take_ring;
			idx_s1       <= idx_d;
			status_s1    <= status_d;
			fcnt_s1      <= FCNT_W'(total_next);
		end
	end

	// offset = index * block size rounded up to 8
	assign aligned_sum = ALIGNED_W'(block_bytes_q) + ALIGNED_W'(7);
	assign aligned     = {aligned_sum[ALIGNED_W-1:3], 3'b000};
	assign idx_sel     = from_ring_s1 ? IDX_W'(rd_s1) : IDX_W'(idx_s1);
	assign product     = PRD_W'(idx_sel) * PRD_W'(aligned);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			rsp_q.block_index  <= idx_sel[BLK_IDX_W-1:0];
			rsp_q.block_offset <= product[BLK_OFF_W-1:0];
			rsp_q.status       <= status_s1;
			rsp_q.free_count   <= fcnt_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_prefill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		prefill_q <= eff_init)
		else $error("prefill pointer past pre-filled region");

	a_exhaust_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_EXHAUSTED) |->
		(rsp.block_index == '0 && rsp.block_offset == '0))
		else $error("exhausted result carries a block");

	a_free_queues: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_we && req.mode == MODE_FREE && free_ok) |=>
		(ring_cnt_q == CNT_W'($past(ring_cnt_q) + 1'b1)))
		else $error("accepted free not queued in ring");

	a_ring_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ring_cnt_q <= MAX_CNT)
		else $error("ring count above pool size");
`endif

endmodule

`default_nettype wire
